// File: hdl/pease_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Parabolic ease-in/ease-out package
// Shared types and register indexes of the easing pipeline.
// ----------------------------------------------------------------------------
package pease_pkg;

  typedef enum logic [1:0] {
    SEG_ACCEL,
    SEG_CRUISE,
    SEG_DECEL
  } pease_seg_e;

  localparam logic REG_EASE_IN  = 1'b0;
  localparam logic REG_EASE_OUT = 1'b1;

endpackage
`default_nettype wire

// File: hdl/parabolic_ease_in_out_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Parabolic ease-in/ease-out unit
// Maps a normalized time to a position along an accelerate, cruise and
// decelerate profile, in unsigned fixed point with FRAC_BITS fraction bits.
//
// The slave stream carries time_in in tdata. Each transfer gives one result on
// the master stream: position in tdata and the clamp flag in tuser.
// Two registers hold the ease-in and ease-out fractions; both reset to zero.
// The user must write them through the cfg port only while no item is in
// flight; the block does not enforce this. The pipeline is an input register,
// a multiplier stage, a numerator/denominator select stage and one restoring
// divider stage per quotient bit. One transfer is taken every cycle while
// there is room. When the receiver stalls, empty stages still fill; the input
// side stops only when every stage holds an item. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module parabolic_ease_in_out_unit
  import pease_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [FRAC_BITS:0]               cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // time_in
  input  wire logic [((FRAC_BITS+8)/8)*8-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // position
  output logic [((FRAC_BITS+8)/8)*8-1:0]        m_axis_tdata,
  // time_clamped
  output logic                                  m_axis_tuser
);

  localparam int F     = FRAC_BITS;
  localparam int DataW = ((F + 8) / 8) * 8;
  localparam int SW    = F + 2;
  localparam int PW    = 2 * F + 4;
  localparam int NumW  = 3 * F + 4;
  localparam int DenW  = 2 * F + 4;
  localparam int QuoW  = F + 1;
  localparam logic [SW-1:0] One = SW'(1) << F;

  logic [F:0] ease_in_q, ease_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ease_in_q  <= '0;
      ease_out_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EASE_IN:  ease_in_q  <= cfg_data_i;
        REG_EASE_OUT: ease_out_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SW-1:0] a_w, b_w, v_w, rem_w, tb2_w;
  logic [SW-1:0] ein_w, eout_w;

  assign ein_w  = SW'(ease_in_q);
  assign eout_w = SW'(ease_out_q);
  assign b_w    = One - ((eout_w > One) ? One : eout_w);
  assign a_w    = (((ein_w > One) ? One : ein_w) > b_w) ? b_w :
                  ((ein_w > One) ? One : ein_w);
  assign v_w    = One + b_w - a_w;
  assign rem_w  = One - b_w;
  assign tb2_w  = (b_w << 1) - a_w;

  logic        vld0_q, vld1_q, vld2_q;
  logic        adv0, adv1, adv2;
  logic        div_ready;

  logic [SW-1:0] t0_q;
  logic          clp0_q;
  logic [F:0]    raw_w;

  assign raw_w = s_axis_tdata[F:0];
  assign adv2  = !vld2_q || div_ready;
  assign adv1  = !vld1_q || adv2;
  assign adv0  = !vld0_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (adv0) vld0_q <= s_axis_tvalid;
      if (adv1) vld1_q <= vld0_q;
      if (adv2) vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      clp0_q <= SW'(raw_w) > One;
      t0_q   <= (SW'(raw_w) > One) ? One : SW'(raw_w);
    end
  end

  pease_seg_e    seg1_q;
  logic [PW-1:0] p_tt_q, p_va_q, p_head_q, p_tail_q, p_rv_q;
  logic [SW-1:0] lin1_q, v1_q;
  logic          clp1_q;
  pease_seg_e    seg_w;

  always_comb begin
    if (t0_q < a_w) begin
      seg_w = SEG_ACCEL;
    end else if (t0_q <= b_w) begin
      seg_w = SEG_CRUISE;
    end else begin
      seg_w = SEG_DECEL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      seg1_q   <= seg_w;
      p_tt_q   <= PW'(t0_q) * PW'(t0_q);
      p_va_q   <= PW'(v_w) * PW'(a_w);
      p_head_q <= PW'(tb2_w) * PW'(rem_w);
      p_tail_q <= PW'(SW'(t0_q - b_w)) * PW'(SW'((One << 1) - t0_q - b_w));
      p_rv_q   <= PW'(rem_w) * PW'(v_w);
      lin1_q   <= (t0_q << 1) - a_w;
      v1_q     <= v_w;
      clp1_q   <= clp0_q;
    end
  end

  logic [NumW-1:0] num2_q;
  logic [DenW-1:0] den2_q;
  logic            clp2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      clp2_q <= clp1_q;
      case (seg1_q)
        SEG_ACCEL: begin
          num2_q <= NumW'(p_tt_q) << F;
          den2_q <= DenW'(p_va_q);
        end
        SEG_CRUISE: begin
          num2_q <= NumW'(lin1_q) << F;
          den2_q <= DenW'(v1_q);
        end
        default: begin
          num2_q <= NumW'(PW'(p_head_q + p_tail_q)) << F;
          den2_q <= DenW'(p_rv_q);
        end
      endcase
    end
  end

  logic [QuoW-1:0] quo_w;
  logic            clp_out_w;

  pease_div #(
    .NumW (NumW),
    .DenW (DenW),
    .QuoW (QuoW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld2_q),
    .in_ready_o  (div_ready),
    .num_i       (num2_q),
    .den_i       (den2_q),
    .tag_i       (clp2_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .quo_o       (quo_w),
    .tag_o       (clp_out_w)
  );

  assign s_axis_tready = adv0;
  assign m_axis_tdata  = DataW'((SW'(quo_w) > One) ? One : SW'(quo_w));
  assign m_axis_tuser  = clp_out_w;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (SW'(m_axis_tdata[F:0]) <= One))
    else $error("position above one");

  a_clamp_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (SW'(m_axis_tdata[F:0]) == One))
    else $error("clamped time did not give full position");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && vld0_q && vld2_q))
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// File: hdl/pease_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with a valid bit and bubble collapsing per stage.
// ----------------------------------------------------------------------------
module pease_div
  import pease_pkg::*;
#(
  parameter int NumW = 52,
  parameter int DenW = 35,
  parameter int QuoW = 17
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic            tag_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [QuoW-1:0]      quo_o,
  output logic                 tag_o
);

  logic [NumW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic            tag_q [QuoW];
  logic [QuoW-1:0] vld_q;
  logic [QuoW-1:0] adv;

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int K = QuoW - 1 - i;
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic            tag_in;
    logic            vld_in;
    logic [NumW:0]   trial;
    logic            fits;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = in_valid_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign tag_in = tag_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    if (i == QuoW - 1) begin : g_last
      assign adv[i] = !vld_q[i] || out_ready_i;
    end else begin : g_mid
      assign adv[i] = !vld_q[i] || adv[i+1];
    end

    assign trial = (NumW+1)'(den_in) << K;
    assign fits  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        rem_q[i] <= fits ? NumW'({1'b0, rem_in} - trial) : rem_in;
        den_q[i] <= den_in;
        quo_q[i] <= fits ? (quo_in | (QuoW'(1) << K)) : quo_in;
        tag_q[i] <= tag_in;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[QuoW-1];
  assign quo_o       = quo_q[QuoW-1];
  assign tag_o       = tag_q[QuoW-1];

endmodule
`default_nettype wire
